// ===== hdl/mme_pkg.sv =====
// shared types and constants for the matrix multiply engine
`timescale 1ns / 1ps

package mme_pkg;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic [1:0] {
    KIND_WRITE_A,
    KIND_WRITE_B,
    KIND_QUERY,
    KIND_REJECT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic [SIZE_W-1:0]        nk;
    logic signed [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result;
    logic                    error;
  } res_t;

endpackage

// ===== hdl/mme_queue.sv =====
// small first-in first-out queue with full and empty flags
`timescale 1ns / 1ps

module mme_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/mme_front.sv =====
// front end: size registers, request classification and command queue
`timescale 1ns / 1ps

module mme_front #(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           opcode_i,
  input  logic [mme_pkg::IDX_W-1:0]            row_i,
  input  logic [mme_pkg::IDX_W-1:0]            col_i,
  input  logic signed [mme_pkg::VAL_W-1:0]     value_i,
  input  logic                                 cfg_we_i,
  input  logic [mme_pkg::REG_IDX_W-1:0]        cfg_addr_i,
  input  logic [mme_pkg::SIZE_W-1:0]           cfg_wdata_i,
  input  logic                                 cmd_pop_i,
  output mme_pkg::cmd_t                        cmd_o,
  output logic                                 cmd_empty_o
);

  import mme_pkg::*;

  logic [SIZE_W-1:0] rows_q, rows_d;
  logic [SIZE_W-1:0] inner_q, inner_d;
  logic [SIZE_W-1:0] cols_q, cols_d;
  cmd_t              cmd_in;

  // index must lie below both the configured size and the store dimension
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] size);
    idx_ok = (SIZE_W'(idx) < size) && (32'(idx) < MAX_DIM);
  endfunction

  always_comb begin
    rows_d  = rows_q;
    inner_d = inner_q;
    cols_d  = cols_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_ROWS_A:     rows_d  = cfg_wdata_i;
        REG_INNER_SIZE: inner_d = cfg_wdata_i;
        REG_COLS_B:     cols_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= SIZE_RESET;
      inner_q <= SIZE_RESET;
      cols_q  <= SIZE_RESET;
    end else begin
      rows_q  <= rows_d;
      inner_q <= inner_d;
      cols_q  <= cols_d;
    end
  end

  always_comb begin
    cmd_in.row   = row_i;
    cmd_in.col   = col_i;
    cmd_in.value = value_i;
    // inner size saturates at the store dimension
    cmd_in.nk    = (32'(inner_q) > MAX_DIM) ? SIZE_W'(MAX_DIM) : inner_q;
    cmd_in.kind  = KIND_REJECT;
    unique case (opcode_i)
      OP_WRITE_A: begin
        if (idx_ok(row_i, rows_q) && idx_ok(col_i, inner_q)) begin
          cmd_in.kind = KIND_WRITE_A;
        end
      end
      OP_WRITE_B: begin
        if (idx_ok(row_i, inner_q) && idx_ok(col_i, cols_q)) begin
          cmd_in.kind = KIND_WRITE_B;
        end
      end
      OP_QUERY: begin
        if (idx_ok(row_i, rows_q) && idx_ok(col_i, cols_q)) begin
          cmd_in.kind = KIND_QUERY;
        end
      end
      default: cmd_in.kind = KIND_REJECT;
    endcase
  end

  mme_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (2)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// ===== hdl/mme_back.sv =====
// back end: matrix stores and the multiply-accumulate sequencer
`timescale 1ns / 1ps

module mme_back #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mme_pkg::cmd_t  cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output mme_pkg::res_t  res_o,
  input  logic           res_full_i,
  output logic           res_push_o
);

  import mme_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(MAX_DIM * MAX_DIM);
  localparam logic [AW-1:0] DIM_STRIDE = AW'(MAX_DIM);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

  logic [1:0]            state_q, state_d;
  cmd_t                  cur_q, cur_d;
  logic [SIZE_W-1:0]     k_q, k_d;
  logic                  err_q, err_d;
  logic [ELEM_WIDTH-1:0] acc_q, acc_d;
  logic [ELEM_WIDTH-1:0] a_rdata_q, b_rdata_q, prod_q;
  logic                  rd_v_q, prod_v_q;
  logic                  issue_v;
  logic                  a_we, b_we;
  logic [AW-1:0]         waddr, a_raddr, b_raddr;
  logic [ELEM_WIDTH-1:0] wdata;

  assign waddr   = AW'(cmd_i.row) * DIM_STRIDE + AW'(cmd_i.col);
  assign wdata   = ELEM_WIDTH'($signed(cmd_i.value));
  assign a_raddr = AW'(cur_q.row) * DIM_STRIDE + AW'(k_q);
  assign b_raddr = AW'(k_q) * DIM_STRIDE + AW'(cur_q.col);

  assign res_o.result = VAL_W'(acc_q);
  assign res_o.error  = err_q;

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    k_d        = k_q;
    err_d      = err_q;
    acc_d      = acc_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    issue_v    = 1'b0;
    a_we       = 1'b0;
    b_we       = 1'b0;
    if (prod_v_q) begin
      acc_d = acc_q + prod_q;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          k_d       = '0;
          acc_d     = '0;
          err_d     = (cmd_i.kind == KIND_REJECT);
          a_we      = (cmd_i.kind == KIND_WRITE_A);
          b_we      = (cmd_i.kind == KIND_WRITE_B);
          // a query over an empty inner dimension sums nothing
          if (cmd_i.kind == KIND_QUERY && cmd_i.nk != '0) begin
            state_d = ST_RUN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RUN: begin
        issue_v = 1'b1;
        k_d     = k_q + 1'b1;
        if (k_q == cur_q.nk - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last product to land in the accumulator
        if (!rd_v_q && !prod_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_v_q   <= 1'b0;
      prod_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_v_q   <= issue_v;
      prod_v_q <= rd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    k_q    <= k_d;
    err_q  <= err_d;
    acc_q  <= acc_d;
    prod_q <= ELEM_WIDTH'(a_rdata_q * b_rdata_q);
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      mem_a[waddr] <= wdata;
    end
    if (b_we) begin
      mem_b[waddr] <= wdata;
    end
    a_rdata_q <= mem_a[a_raddr];
    b_rdata_q <= mem_b[b_raddr];
  end

endmodule

// ===== hdl/matrix_multiply_engine_top.sv =====
// top level of the matrix multiply engine: front end, back end and result queue
// back end takes one request at a time; a write, a rejected request or a query with no
// inner terms goes straight to its result, while other queries run over inner_size
// (capped at MAX_DIM) terms, one multiply-accumulate per cycle over the single read
// port of each store
// reset clears queues, sequencer and sets all three sizes to 16; stores stay undefined
`timescale 1ns / 1ps

module matrix_multiply_engine_top #(
  parameter int unsigned MAX_DIM    = 16,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        opcode_i,
  input  logic [mme_pkg::IDX_W-1:0]         row_i,
  input  logic [mme_pkg::IDX_W-1:0]         col_i,
  input  logic signed [mme_pkg::VAL_W-1:0]  value_i,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [mme_pkg::VAL_W-1:0]  result_o,
  output logic                              error_o,
  input  logic                              cfg_we_i,
  input  logic [mme_pkg::REG_IDX_W-1:0]     cfg_addr_i,
  input  logic [mme_pkg::SIZE_W-1:0]        cfg_wdata_i
);

  import mme_pkg::*;

  cmd_t cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  mme_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  mme_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_full_i  (res_full),
    .res_push_o  (res_push)
  );

  mme_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (2)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign result_o = res_out.result;
  assign error_o  = res_out.error;

  a_res_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  a_cmd_pop_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command taken from an empty command queue");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (result_o == '0))
    else $error("rejected request carries a non-zero result");

endmodule
